[rtl/imuafd_pkg.sv]
// shared types and constants of the imu angle frame decoder
`default_nettype none
package imuafd_pkg;

    localparam logic [7:0] HDR_FIRST   = 8'h55;
    localparam logic [7:0] HDR_SECOND  = 8'h53;
    localparam logic [7:0] CALIB_RESET = 8'd200;
    localparam int PAYLOAD_LEN = 8;
    localparam int ANGLE_W     = 17;
    localparam int RATE_W      = 26;
    localparam int ACC_W       = 24;
    localparam int DIV_W       = 26;
    localparam int DVS_W       = 32;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 136;
    localparam int OUT_USER_W  = 2;

    typedef enum logic [1:0] {
        P_HUNT1,
        P_HUNT2,
        P_PAYLOAD,
        P_CHECK
    } parse_phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OFFS_GO,
        S_OFFS_WAIT,
        S_CORR,
        S_RATE_GO,
        S_RATE_WAIT,
        S_OUT
    } seq_state_t;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [DVS_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_W-1:0]   quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

[rtl/imuafd_div.sv]
// bit-serial restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module imuafd_div (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire imuafd_pkg::div_req_t req,
    output imuafd_pkg::div_rsp_t      rsp
);
    import imuafd_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [DVS_W-1:0]   rem_reg;
    logic [DVS_W-1:0]   dvs_reg;
    logic [DVS_W:0]     trial;
    logic [DVS_W:0]     diff;
    logic               ge;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

[rtl/imu_angle_frame_decoder_top.sv]
// top level of the imu angle frame decoder
`default_nettype none
// Takes one received byte with its millisecond timestamp per request on the
// slave stream, hunts for the 0x55 0x53 header, collects eight payload bytes
// in a byte shift register and checks the 8-bit sum. A good frame yields one
// request on the master stream with roll, pitch and yaw, offset-corrected once
// calibration is done, and their rates. A good checksum byte starts a
// sequencer that shares one bit-serial divider, and the input stays closed
// until the sequencer is back in idle. Each rate has a start state, then waits
// on the 26 quotient bits and the done flag. A corrected frame goes through
// correction, three rates and output load, a calibration frame skips the
// correction, and the single frame that forms the offsets first adds three
// offset divisions if any calibration frame was counted. With zero elapsed
// time the divider is skipped and each rate is set in its start state. The
// output load waits while an earlier result is still held; once loaded, new
// bytes are taken while it waits in the output register.
module imu_angle_frame_decoder_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [7:0]                          cfg_wdata,   // calib_frames
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [imuafd_pkg::IN_DATA_W-1:0]    s_tdata,     // rx_byte, time_ms
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // roll, pitch, yaw, roll_rate, pitch_rate, yaw_rate, zero pad
    output logic [imuafd_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic [imuafd_pkg::OUT_USER_W-1:0]        m_tuser      // calibrated, rate_saturated
);
    import imuafd_pkg::*;

    localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

    // configuration and parser
    logic [7:0]                 cfg_reg;
    parse_phase_t               phase_reg;
    logic [3:0]                 cnt_reg;
    logic [7:0]                 sum_reg;
    logic [8*PAYLOAD_LEN-1:0]   pay_reg;

    // calibration and rate state
    logic [8:0]                         fs_reg;
    logic signed [ACC_W-1:0]            acc_reg  [3];
    logic                               ready_reg;
    logic signed [ANGLE_W-1:0]          prev_reg [3];
    logic [31:0]                        last_reg;
    logic [31:0]                        dt_reg;
    logic signed [ANGLE_W-1:0]          ang_reg  [3];
    logic signed [RATE_W-1:0]           rate_reg [3];
    logic                               sat_reg;

    // sequencer
    seq_state_t     state_reg;
    seq_state_t     state_next;
    logic [1:0]     k_reg;

    // output register
    logic                       out_valid_reg;
    logic [OUT_DATA_W-1:0]      out_data_reg;
    logic [OUT_USER_W-1:0]      out_user_reg;

    logic           s_acc;
    logic [7:0]     rx_byte;
    logic [31:0]    time_ms;
    logic           good;
    logic           calib_add;
    logic           out_load;
    logic [1:0]     kk;
    logic signed [ANGLE_W-1:0] raw [3];
    logic signed [ACC_W-1:0]   acc_k;
    logic signed [ANGLE_W:0]   diff_k;
    logic signed [RATE_W-1:0]  num_k;
    logic                      acc_neg;
    logic                      num_neg;
    logic [DIV_W-1:0]          quo;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    assign rx_byte = s_tdata[7:0];
    assign time_ms = s_tdata[39:8];
    assign s_acc   = s_tvalid && s_tready;
    assign good    = (phase_reg == P_CHECK) && (rx_byte == sum_reg);
    assign calib_add = !ready_reg && (fs_reg < {1'b0, cfg_reg});

    // little-endian int16 angles from the payload shift register
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            raw[i] = ANGLE_W'(signed'(pay_reg[16*i +: 16]));
        end
    end

    // per-axis selection; index three never occurs
    assign kk      = (k_reg == 2'd3) ? 2'd2 : k_reg;
    assign acc_k   = acc_reg[kk];
    assign acc_neg = acc_k[ACC_W-1];
    assign diff_k  = (ANGLE_W+1)'(prev_reg[kk]) - (ANGLE_W+1)'(ang_reg[kk]);
    assign num_k   = {diff_k[RATE_W-9:0], 8'd0};
    assign num_neg = diff_k[ANGLE_W];
    assign quo     = div_rsp.quotient;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    imuafd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_acc && good)
                begin
                    priority if (calib_add)
                        state_next = S_RATE_GO;
                    else if (!ready_reg && fs_reg != 9'd0)
                        state_next = S_OFFS_GO;
                    else
                        state_next = S_CORR;
                end
            end
            S_OFFS_GO:   state_next = S_OFFS_WAIT;
            S_OFFS_WAIT:
            begin
                if (div_rsp.done)
                    state_next = (k_reg == 2'd2) ? S_CORR : S_OFFS_GO;
            end
            S_CORR:      state_next = S_RATE_GO;
            S_RATE_GO:
            begin
                if (dt_reg == 32'd0)
                    state_next = (k_reg == 2'd2) ? S_OUT : S_RATE_GO;
                else
                    state_next = S_RATE_WAIT;
            end
            S_RATE_WAIT:
            begin
                if (div_rsp.done)
                    state_next = (k_reg == 2'd2) ? S_OUT : S_RATE_GO;
            end
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            S_IDLE:      s_tready = 1'b1;
            S_OFFS_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(acc_neg ? -acc_k : acc_k);
                div_req.divisor  = DVS_W'(fs_reg);
            end
            S_RATE_GO:
            begin
                div_req.start    = (dt_reg != 32'd0);
                div_req.dividend = num_neg ? DIV_W'(-num_k) : DIV_W'(num_k);
                div_req.divisor  = dt_reg;
            end
            default:     s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CALIB_RESET;
            phase_reg     <= P_HUNT1;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            fs_reg        <= '0;
            ready_reg     <= 1'b0;
            last_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i]  <= '0;
                prev_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                cfg_reg <= cfg_wdata;

            if (s_acc)
            begin
                unique case (phase_reg)
                    P_HUNT1:
                    begin
                        if (rx_byte == HDR_FIRST)
                            phase_reg <= P_HUNT2;
                    end
                    P_HUNT2:
                    begin
                        if (rx_byte == HDR_SECOND)
                        begin
                            phase_reg <= P_PAYLOAD;
                            cnt_reg   <= '0;
                            sum_reg   <= HDR_FIRST + HDR_SECOND;
                        end
                    end
                    P_PAYLOAD:
                    begin
                        sum_reg <= sum_reg + rx_byte;
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == 4'(PAYLOAD_LEN - 1))
                            phase_reg <= P_CHECK;
                    end
                    P_CHECK:     phase_reg <= P_HUNT1;
                    default:     phase_reg <= P_HUNT1;
                endcase

                if (good)
                begin
                    last_reg <= time_ms;
                    k_reg    <= '0;
                    if (calib_add)
                    begin
                        // calibration frame: accumulate raw angles
                        for (int i = 0; i < 3; i++)
                            acc_reg[i] <= acc_reg[i] + ACC_W'(raw[i]);
                        fs_reg <= fs_reg + 1'b1;
                    end
                    else if (!ready_reg)
                    begin
                        // offset frame; with no frames counted the offsets are zero
                        ready_reg <= 1'b1;
                        if (fs_reg == 9'd0)
                        begin
                            for (int i = 0; i < 3; i++)
                                acc_reg[i] <= '0;
                        end
                    end
                end
            end

            unique case (state_reg)
                S_OFFS_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        acc_reg[kk] <= acc_neg ? -ACC_W'(quo) : ACC_W'(quo);
                        k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 1'b1;
                    end
                end
                S_RATE_GO:
                begin
                    if (dt_reg == 32'd0)
                    begin
                        prev_reg[kk] <= ang_reg[kk];
                        k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 1'b1;
                    end
                end
                S_RATE_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        prev_reg[kk] <= ang_reg[kk];
                        k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        if (s_acc && phase_reg == P_PAYLOAD)
            pay_reg <= {rx_byte, pay_reg[8*PAYLOAD_LEN-1:8]};

        if (s_acc && good)
        begin
            dt_reg  <= time_ms - last_reg;
            sat_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                ang_reg[i] <= raw[i];
        end

        unique case (state_reg)
            S_CORR:
            begin
                for (int i = 0; i < 3; i++)
                    ang_reg[i] <= ang_reg[i] - acc_reg[i][ANGLE_W-1:0];
            end
            S_RATE_GO:
            begin
                if (dt_reg == 32'd0)
                begin
                    sat_reg <= 1'b1;
                    priority if (diff_k == '0)
                        rate_reg[kk] <= '0;
                    else if (num_neg)
                        rate_reg[kk] <= RATE_MIN;
                    else
                        rate_reg[kk] <= RATE_MAX;
                end
            end
            S_RATE_WAIT:
            begin
                if (div_rsp.done)
                    rate_reg[kk] <= num_neg ? -RATE_W'(quo) : RATE_W'(quo);
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_data_reg <= {7'd0, rate_reg[2], rate_reg[1], rate_reg[0],
                             ang_reg[2], ang_reg[1], ang_reg[0]};
            out_user_reg <= {sat_reg, ready_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // no new byte is taken while a frame is being worked out
    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !s_tready)
        else $error("byte taken while sequencer busy");

    // the divider is started only from a start state
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (state_reg == S_OFFS_GO || state_reg == S_RATE_GO))
        else $error("divider started outside a start state");

    // calibration never runs again once offsets are ready
    a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |=> ready_reg)
        else $error("offset ready dropped");

endmodule
`default_nettype wire
